// File: rtl/core/slc_pkg.sv
// ----------------------------------------------------------------------------
// slc_pkg
// Shared types and character codes for the source line counter.
// ----------------------------------------------------------------------------
package slc_pkg;

   // default sizes of the running totals and of the pending statement count
   localparam int unsigned COUNT_BITS_DEFAULT   = 32;
   localparam int unsigned PENDING_BITS_DEFAULT = 16;

   // width of each result field
   localparam int unsigned FIELD_BITS = 32;

   // character codes the scanner reacts to
   localparam logic [7:0] CHR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHR_HASH      = 8'h23;
   localparam logic [7:0] CHR_SEMICOLON = 8'h3B;
   localparam logic [7:0] CHR_LBRACE    = 8'h7B;
   localparam logic [7:0] CHR_RBRACE    = 8'h7D;
   localparam logic [7:0] CHR_COLON     = 8'h3A;
   localparam logic [7:0] CHR_DQUOTE    = 8'h22;
   localparam logic [7:0] CHR_SQUOTE    = 8'h27;
   localparam logic [7:0] CHR_STAR      = 8'h2A;
   localparam logic [7:0] CHR_SLASH     = 8'h2F;
   localparam logic [7:0] CHR_SPACE     = 8'h20;
   localparam logic [7:0] CHR_TAB       = 8'h09;

   // one request: a source byte or the end-of-text mark
   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } req_type;

   // one result: the three totals
   typedef struct packed {
      logic [FIELD_BITS-1:0] physical_lines;
      logic [FIELD_BITS-1:0] logical_lines;
      logic [FIELD_BITS-1:0] comment_lines;
   } rsp_type;

endpackage

// File: rtl/core/source_line_counter_core.sv
// ----------------------------------------------------------------------------
// source_line_counter_core
// Scans C source text a byte per request and keeps physical, logical and
// comment line totals; an end-of-text request returns them and clears all.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake              payload
//   req       in          req_valid / req_stall  slc_pkg::req_type
//   rsp       out         rsp_valid / rsp_stall  slc_pkg::rsp_type
//
// A byte request updates the scanner state at its accept edge, and an
// end-of-text request loads the result register at its accept edge, so a
// result appears in the next cycle. Sustained rate is one request per cycle
// while no end-of-text request is stalled, set by the single state update.
// Reset (synchronous) clears the scanner state and the result valid.
// Byte requests are never stalled; an end-of-text request is stalled only
// while an earlier result still waits in the result register.
// ----------------------------------------------------------------------------
module source_line_counter_core #(
   parameter int unsigned COUNT_BITS   = slc_pkg::COUNT_BITS_DEFAULT,
   parameter int unsigned PENDING_BITS = slc_pkg::PENDING_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  slc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output slc_pkg::rsp_type rsp_data
);

   localparam int unsigned SUM_BITS =
      ((COUNT_BITS > PENDING_BITS) ? COUNT_BITS : PENDING_BITS) + 2;
   localparam int unsigned EXT_BITS =
      (COUNT_BITS > slc_pkg::FIELD_BITS) ? COUNT_BITS : slc_pkg::FIELD_BITS;
   localparam logic [COUNT_BITS-1:0]   COUNT_MAX   = {COUNT_BITS{1'b1}};
   localparam logic [PENDING_BITS-1:0] PENDING_MAX = {PENDING_BITS{1'b1}};

   // scanner state
   logic in_block_ff, in_block_in;
   logic in_line_ff, in_line_in;
   logic in_string_ff, in_string_in;
   logic in_char_ff, in_char_in;
   logic escape_ff, escape_in;
   logic preproc_ff, preproc_in;
   logic has_code_ff, has_code_in;
   logic after_brace_ff, after_brace_in;
   logic after_colon_ff, after_colon_in;
   logic [PENDING_BITS-1:0] pending_ff, pending_in;
   logic [7:0]              prev_byte_ff, prev_byte_in;
   logic [COUNT_BITS-1:0]   physical_ff, physical_in;
   logic [COUNT_BITS-1:0]   logical_ff, logical_in;
   logic [COUNT_BITS-1:0]   comment_ff, comment_in;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   slc_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic             req_accept;
   logic             eot_accept;
   logic [7:0]       byte_val;
   logic [SUM_BITS-1:0] logical_sum;
   logic [EXT_BITS-1:0] physical_ext, logical_ext, comment_ext;

   // hold an end-of-text request while the previous result is not taken
   assign req_stall  = req_valid && req_data.end_of_text && rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign eot_accept = req_accept && req_data.end_of_text;
   assign byte_val   = req_data.text_byte;

   // logical total plus line flag plus pending count, saturated once
   assign logical_sum = SUM_BITS'(logical_ff)
                      + SUM_BITS'(preproc_ff || after_colon_ff)
                      + SUM_BITS'(pending_ff);

   // next scanner state for one byte
   always_comb begin
      in_block_in    = in_block_ff;
      in_line_in     = in_line_ff;
      in_string_in   = in_string_ff;
      in_char_in     = in_char_ff;
      escape_in      = escape_ff;
      preproc_in     = preproc_ff;
      has_code_in    = has_code_ff;
      after_brace_in = after_brace_ff;
      after_colon_in = after_colon_ff;
      pending_in     = pending_ff;
      prev_byte_in   = byte_val;
      physical_in    = physical_ff;
      logical_in     = logical_ff;
      comment_in     = comment_ff;

      if (escape_ff) begin
         escape_in = 1'b0;
      end else if (byte_val == slc_pkg::CHR_BACKSLASH) begin
         escape_in = 1'b1;
      end else if (in_block_ff) begin
         // count comment newlines and the closing star-slash
         if (byte_val == slc_pkg::CHR_NEWLINE ||
             (prev_byte_ff == slc_pkg::CHR_STAR && byte_val == slc_pkg::CHR_SLASH)) begin
            if (comment_ff != COUNT_MAX) comment_in = comment_ff + 1'b1;
         end
         if (prev_byte_ff == slc_pkg::CHR_STAR && byte_val == slc_pkg::CHR_SLASH) begin
            in_block_in = 1'b0;
         end
      end else if (in_line_ff) begin
         if (byte_val == slc_pkg::CHR_NEWLINE) begin
            if (comment_ff != COUNT_MAX) comment_in = comment_ff + 1'b1;
            in_line_in = 1'b0;
         end
      end else if (in_string_ff) begin
         if (byte_val == slc_pkg::CHR_DQUOTE) in_string_in = 1'b0;
      end else if (in_char_ff) begin
         if (byte_val == slc_pkg::CHR_SQUOTE) in_char_in = 1'b0;
      end else begin
         case (byte_val)
            slc_pkg::CHR_NEWLINE: begin
               // fold the line flags into the totals
               if (has_code_ff && physical_ff != COUNT_MAX) physical_in = physical_ff + 1'b1;
               if (logical_sum > SUM_BITS'(COUNT_MAX)) logical_in = COUNT_MAX;
               else logical_in = logical_sum[COUNT_BITS-1:0];
               preproc_in     = 1'b0;
               after_brace_in = 1'b0;
               after_colon_in = 1'b0;
               has_code_in    = 1'b0;
               pending_in     = '0;
            end
            slc_pkg::CHR_HASH: begin
               preproc_in = 1'b1;
            end
            slc_pkg::CHR_STAR: begin
               if (prev_byte_ff == slc_pkg::CHR_SLASH) in_block_in = 1'b1;
            end
            slc_pkg::CHR_SLASH: begin
               if (prev_byte_ff == slc_pkg::CHR_SLASH) in_line_in = 1'b1;
            end
            slc_pkg::CHR_DQUOTE: begin
               in_string_in = 1'b1;
               has_code_in  = 1'b1;
            end
            slc_pkg::CHR_SQUOTE: begin
               in_char_in  = 1'b1;
               has_code_in = 1'b1;
            end
            slc_pkg::CHR_SPACE, slc_pkg::CHR_TAB: begin
               has_code_in = has_code_ff;
            end
            slc_pkg::CHR_SEMICOLON: begin
               has_code_in = 1'b1;
               if (!after_brace_ff && pending_ff != PENDING_MAX) pending_in = pending_ff + 1'b1;
               after_brace_in = 1'b0;
               after_colon_in = 1'b0;
            end
            slc_pkg::CHR_COLON: begin
               has_code_in    = 1'b1;
               after_colon_in = 1'b1;
            end
            slc_pkg::CHR_LBRACE: begin
               if (pending_ff != PENDING_MAX) pending_in = pending_ff + 1'b1;
               has_code_in = 1'b1;
            end
            slc_pkg::CHR_RBRACE: begin
               after_brace_in = 1'b1;
               has_code_in    = 1'b1;
            end
            default: begin
               has_code_in = 1'b1;
            end
         endcase
      end
   end

   // pick the low field bits of each total
   assign physical_ext = EXT_BITS'(physical_ff);
   assign logical_ext  = EXT_BITS'(logical_ff);
   assign comment_ext  = EXT_BITS'(comment_ff);

   // load a result on end of text, drop it once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (eot_accept) begin
         rsp_valid_in               = 1'b1;
         rsp_data_in.physical_lines = physical_ext[slc_pkg::FIELD_BITS-1:0];
         rsp_data_in.logical_lines  = logical_ext[slc_pkg::FIELD_BITS-1:0];
         rsp_data_in.comment_lines  = comment_ext[slc_pkg::FIELD_BITS-1:0];
      end
   end

   // advance the scanner; clear it on reset or end of text
   always_ff @(posedge clock) begin
      if (reset || eot_accept) begin
         in_block_ff    <= 1'b0;
         in_line_ff     <= 1'b0;
         in_string_ff   <= 1'b0;
         in_char_ff     <= 1'b0;
         escape_ff      <= 1'b0;
         preproc_ff     <= 1'b0;
         has_code_ff    <= 1'b0;
         after_brace_ff <= 1'b0;
         after_colon_ff <= 1'b0;
         pending_ff     <= '0;
         prev_byte_ff   <= '0;
         physical_ff    <= '0;
         logical_ff     <= '0;
         comment_ff     <= '0;
      end else if (req_accept) begin
         in_block_ff    <= in_block_in;
         in_line_ff     <= in_line_in;
         in_string_ff   <= in_string_in;
         in_char_ff     <= in_char_in;
         escape_ff      <= escape_in;
         preproc_ff     <= preproc_in;
         has_code_ff    <= has_code_in;
         after_brace_ff <= after_brace_in;
         after_colon_ff <= after_colon_in;
         pending_ff     <= pending_in;
         prev_byte_ff   <= prev_byte_in;
         physical_ff    <= physical_in;
         logical_ff     <= logical_in;
         comment_ff     <= comment_in;
      end
   end

   // hold the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
